### rtl/vbc_pkg.sv
// ----------------------------------------------------------------------------
// Vertex buffer coalescer package
// Shared sizes, status codes and the request, result and match types.
// ----------------------------------------------------------------------------
package vbc_pkg;

  localparam int MAX_RESOURCES = 16;
  localparam int MAX_ATTRS     = 16;

  localparam int ADDR_W   = 48;
  localparam int STRIDE_W = 14;
  localparam int REC_W    = 32;
  localparam int SLOT_W   = 8;
  localparam int NUM_W    = 4;
  localparam int STAT_W   = 2;

  // Buffer and resource indexes, and counts that can hold the full depth.
  localparam int IDX_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int CNT_W   = $clog2(MAX_RESOURCES + 1);
  localparam int AIDX_W  = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
  localparam int ACNT_W  = $clog2(MAX_ATTRS + 1);
  localparam int LIST_AW = IDX_W + AIDX_W;
  localparam int LIST_DEPTH = 1 << LIST_AW;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RECORDS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ATTR_OVF = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [31:0] descriptor_low;
    logic [31:0] descriptor_high;
    logic [31:0] record_count;
    logic [7:0]  fetch_slot;
    logic        final_item;
  } vbc_in_t;

  typedef struct packed {
    logic [NUM_W-1:0]    buffer_number;
    logic [ADDR_W-1:0]   buffer_address;
    logic [STRIDE_W-1:0] buffer_stride;
    logic [REC_W-1:0]    buffer_records;
    logic [SLOT_W-1:0]   buffer_fetch_slot;
    logic [NUM_W-1:0]    resource_number;
    logic [STRIDE_W-1:0] attribute_offset;
    logic [STAT_W-1:0]   status;
    logic                last_in_run;
  } vbc_out_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] low;
  } vbc_match_t;

endpackage

### rtl/vbc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/vbc_match.sv
// ----------------------------------------------------------------------------
// Buffer match unit
// Compares one descriptor against one stored buffer per cycle.
// ----------------------------------------------------------------------------
module vbc_match import vbc_pkg::*; (
  input  logic [ADDR_W-1:0]   desc_base,
  input  logic [STRIDE_W-1:0] desc_stride,
  input  logic [SLOT_W-1:0]   desc_slot,
  input  logic [ADDR_W-1:0]   buf_base,
  input  logic [STRIDE_W-1:0] buf_stride,
  input  logic [SLOT_W-1:0]   buf_slot,
  output vbc_match_t          result
);

  logic [ADDR_W:0]   diff_db;
  logic [ADDR_W:0]   diff_bd;
  logic              desc_lower;
  logic [ADDR_W-1:0] spread;
  logic              in_reach;

  assign diff_db    = {1'b0, desc_base} - {1'b0, buf_base};
  assign diff_bd    = {1'b0, buf_base} - {1'b0, desc_base};
  assign desc_lower = diff_db[ADDR_W];
  assign spread     = desc_lower ? diff_bd[ADDR_W-1:0] : diff_db[ADDR_W-1:0];

  // Both addresses lie within one stride of the lower one exactly when their
  // distance is below the stride; a zero stride therefore never matches.
  assign in_reach = (spread[ADDR_W-1:STRIDE_W] == '0) &&
                    (spread[STRIDE_W-1:0] < desc_stride);

  assign result.hit = in_reach && (desc_stride == buf_stride) && (desc_slot == buf_slot);
  assign result.low = desc_lower ? desc_base : buf_base;

endmodule

### rtl/vertex_buffer_coalescer_core.sv
// ----------------------------------------------------------------------------
// Vertex buffer coalescer core
// Merges vertex resource descriptors into buffers and lists their attributes.
// ----------------------------------------------------------------------------
// Usage: drive in_desc and raise start; the request is taken on a clock edge
// with start high and busy low. busy stays high while the request is worked.
// A descriptor is compared against the stored buffers in order until it
// merges or opens a new buffer; a dropped one skips the search. One buffer
// is compared per cycle. A final_item descriptor emits its results, each
// through a read step and an emit step, as each attribute's resource index comes from the
// attribute list memory with a registered read. After a sticky error the
// final request gives one result carrying the status instead. Results
// appear on out_res with out_valid high for exactly one cycle each; the
// receiver cannot stall them. The result with last_in_run closes the set,
// and all tables are then empty for the next set.
// Reset (rst_n low, synchronous) empties the tables and clears the error;
// no clearing pass is needed, entries are only read after being written.
// ----------------------------------------------------------------------------
module vertex_buffer_coalescer_core import vbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  vbc_in_t  in_desc,
  output logic     out_valid,
  output vbc_out_t out_res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_DONE   = 5'b00100,
    S_RD     = 5'b01000,
    S_EMIT   = 5'b10000
  } vbc_state_t;

  vbc_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]    bcnt_r, bcnt_nxt;
  logic [STAT_W-1:0]   err_r, err_nxt;
  logic [CNT_W-1:0]    si_r, si_nxt;
  logic [CNT_W-1:0]    ob_r, ob_nxt;
  logic [ACNT_W-1:0]   ok_r, ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  vbc_out_t            out_res_r, out_res_nxt;

  // Latched request.
  logic [ADDR_W-1:0]   d_base_r;
  logic [STRIDE_W-1:0] d_stride_r;
  logic [REC_W-1:0]    d_records_r;
  logic [SLOT_W-1:0]   d_slot_r;
  logic                d_final_r;
  logic [IDX_W-1:0]    d_ri_r;

  // Resource and buffer tables.
  logic [ADDR_W-1:0]   res_base_r   [MAX_RESOURCES];
  logic [ADDR_W-1:0]   tbl_addr_r   [MAX_RESOURCES];
  logic [STRIDE_W-1:0] tbl_stride_r [MAX_RESOURCES];
  logic [REC_W-1:0]    tbl_rec_r    [MAX_RESOURCES];
  logic [SLOT_W-1:0]   tbl_slot_r   [MAX_RESOURCES];
  logic [ACNT_W-1:0]   tbl_acnt_r   [MAX_RESOURCES];

  logic                accept;
  logic [IDX_W-1:0]    si_idx;
  logic [IDX_W-1:0]    bc_idx;
  logic [IDX_W-1:0]    ob_idx;
  vbc_match_t          match;
  logic                do_merge;
  logic                do_new;
  logic                out_load;
  logic                list_we;
  logic [LIST_AW-1:0]  list_waddr;
  logic [LIST_AW-1:0]  list_raddr;
  logic [IDX_W-1:0]    list_rdata;
  logic [ACNT_W-1:0]   ok_inc;
  logic [CNT_W-1:0]    ob_inc;
  logic                attr_last;
  logic                set_last;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign si_idx = si_r[IDX_W-1:0];
  assign bc_idx = bcnt_r[IDX_W-1:0];
  assign ob_idx = ob_r[IDX_W-1:0];

  vbc_match u_match (
    .desc_base   (d_base_r),
    .desc_stride (d_stride_r),
    .desc_slot   (d_slot_r),
    .buf_base    (tbl_addr_r[si_idx]),
    .buf_stride  (tbl_stride_r[si_idx]),
    .buf_slot    (tbl_slot_r[si_idx]),
    .result      (match)
  );

  vbc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (LIST_DEPTH)
  ) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (d_ri_r),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  assign list_raddr = {ob_idx, ok_r[AIDX_W-1:0]};
  assign ok_inc     = ok_r + ACNT_W'(1);
  assign ob_inc     = ob_r + CNT_W'(1);
  assign attr_last  = (ok_inc == tbl_acnt_r[ob_idx]);
  assign set_last   = attr_last && (ob_inc == bcnt_r);

  always_comb begin
    state_nxt     = state_r;
    rcnt_nxt      = rcnt_r;
    bcnt_nxt      = bcnt_r;
    err_nxt       = err_r;
    si_nxt        = si_r;
    ob_nxt        = ob_r;
    ok_nxt        = ok_r;
    out_valid_nxt = 1'b0;
    out_load      = 1'b0;
    out_res_nxt   = '0;
    do_merge      = 1'b0;
    do_new        = 1'b0;
    list_we       = 1'b0;
    list_waddr    = {si_idx, tbl_acnt_r[si_idx][AIDX_W-1:0]};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (err_r != ST_OK) begin
            state_nxt = S_DONE;
          end else if (rcnt_r == CNT_W'(MAX_RESOURCES)) begin
            err_nxt   = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            rcnt_nxt  = rcnt_r + CNT_W'(1);
            si_nxt    = '0;
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (si_r == bcnt_r) begin
          // No stored buffer took the descriptor: open a new one.
          if (bcnt_r == CNT_W'(MAX_RESOURCES)) begin
            err_nxt = ST_FULL;
          end else begin
            do_new     = 1'b1;
            list_we    = 1'b1;
            list_waddr = {bc_idx, {AIDX_W{1'b0}}};
            bcnt_nxt   = bcnt_r + CNT_W'(1);
          end
          state_nxt = S_DONE;
        end else if (match.hit) begin
          if (tbl_rec_r[si_idx] != d_records_r) begin
            err_nxt = ST_RECORDS;
          end else if (tbl_acnt_r[si_idx] == ACNT_W'(MAX_ATTRS)) begin
            err_nxt = ST_ATTR_OVF;
          end else begin
            do_merge = 1'b1;
            list_we  = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          si_nxt = si_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!d_final_r) begin
          state_nxt = S_IDLE;
        end else if (err_r != ST_OK) begin
          out_valid_nxt           = 1'b1;
          out_load                = 1'b1;
          out_res_nxt.status      = err_r;
          out_res_nxt.last_in_run = 1'b1;
          rcnt_nxt                = '0;
          bcnt_nxt                = '0;
          err_nxt                 = ST_OK;
          state_nxt               = S_IDLE;
        end else begin
          ob_nxt    = '0;
          ok_nxt    = '0;
          state_nxt = (bcnt_r == '0) ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt                 = 1'b1;
        out_load                      = 1'b1;
        out_res_nxt.buffer_number     = NUM_W'(ob_idx);
        out_res_nxt.buffer_address    = tbl_addr_r[ob_idx];
        out_res_nxt.buffer_stride     = tbl_stride_r[ob_idx];
        out_res_nxt.buffer_records    = tbl_rec_r[ob_idx];
        out_res_nxt.buffer_fetch_slot = tbl_slot_r[ob_idx];
        out_res_nxt.resource_number   = NUM_W'(list_rdata);
        out_res_nxt.attribute_offset  = res_base_r[list_rdata][STRIDE_W-1:0]
                                        - tbl_addr_r[ob_idx][STRIDE_W-1:0];
        out_res_nxt.status            = ST_OK;
        out_res_nxt.last_in_run       = set_last;
        if (set_last) begin
          rcnt_nxt  = '0;
          bcnt_nxt  = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          if (attr_last) begin
            ob_nxt = ob_inc;
            ok_nxt = '0;
          end else begin
            ok_nxt = ok_inc;
          end
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rcnt_r      <= '0;
      bcnt_r      <= '0;
      err_r       <= ST_OK;
      si_r        <= '0;
      ob_r        <= '0;
      ok_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcnt_r      <= rcnt_nxt;
      bcnt_r      <= bcnt_nxt;
      err_r       <= err_nxt;
      si_r        <= si_nxt;
      ob_r        <= ob_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_base_r    <= {in_desc.descriptor_high[ADDR_W-33:0], in_desc.descriptor_low};
      d_stride_r  <= in_desc.descriptor_high[16 +: STRIDE_W];
      d_records_r <= in_desc.record_count;
      d_slot_r    <= in_desc.fetch_slot;
      d_final_r   <= in_desc.final_item;
      d_ri_r      <= rcnt_r[IDX_W-1:0];
      if (err_r == ST_OK && rcnt_r != CNT_W'(MAX_RESOURCES)) begin
        res_base_r[rcnt_r[IDX_W-1:0]] <=
          {in_desc.descriptor_high[ADDR_W-33:0], in_desc.descriptor_low};
      end
    end
    if (do_new) begin
      tbl_addr_r[bc_idx]   <= d_base_r;
      tbl_stride_r[bc_idx] <= d_stride_r;
      tbl_rec_r[bc_idx]    <= d_records_r;
      tbl_slot_r[bc_idx]   <= d_slot_r;
      tbl_acnt_r[bc_idx]   <= ACNT_W'(1);
    end
    if (do_merge) begin
      tbl_addr_r[si_idx] <= match.low;
      tbl_acnt_r[si_idx] <= tbl_acnt_r[si_idx] + ACNT_W'(1);
    end
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A result only follows the emit or wrap-up step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_EMIT || $past(state_r) == S_DONE))
    else $error("result strobe without an emit step");

  // Every buffer holds at least one descriptor of the set.
  a_buf_le_res: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= rcnt_r)
    else $error("more buffers than descriptors");

  // An error result always closes the set.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |-> out_res_r.last_in_run)
    else $error("error result not marked last");

  // After the closing result the tables are empty.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.last_in_run) |-> (rcnt_r == '0 && bcnt_r == '0 && err_r == ST_OK))
    else $error("state not cleared after the set");

endmodule

### bench/vbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex buffer coalescer checker
// Watches the request and result channels, keeps its own copy of the buffer
// tables, predicts every result and compares each one field by field.
// ----------------------------------------------------------------------------
module vbc_checker import vbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  vbc_in_t  in_desc,
  input  logic     out_valid,
  input  vbc_out_t out_res,
  output int       fail_count,
  output int       expected_left,
  output int       results_seen,
  output int       error_closes
);

  logic [ADDR_W-1:0]   res_base  [MAX_RESOURCES];
  logic [ADDR_W-1:0]   buf_addr  [MAX_RESOURCES];
  logic [STRIDE_W-1:0] buf_strd  [MAX_RESOURCES];
  logic [REC_W-1:0]    buf_rec   [MAX_RESOURCES];
  logic [SLOT_W-1:0]   buf_slt   [MAX_RESOURCES];
  int unsigned         buf_attrs [MAX_RESOURCES];
  logic [NUM_W-1:0]    attr_list [MAX_RESOURCES][MAX_ATTRS];
  int unsigned         res_count;
  int unsigned         buf_count;
  logic [STAT_W-1:0]   sticky_err;
  vbc_out_t            expected_attrs[$];

  function automatic void clear_tables();
    res_count  = 0;
    buf_count  = 0;
    sticky_err = ST_OK;
  endfunction

  // Only the first error of a set is kept.
  function automatic void note_error(input logic [STAT_W-1:0] code);
    if (sticky_err == ST_OK) sticky_err = code;
  endfunction

  function automatic void coalesce_desc(input vbc_in_t d);
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   low;
    logic [STRIDE_W-1:0] strd;
    int unsigned         ri;
    base = {d.descriptor_high[15:0], d.descriptor_low};
    strd = d.descriptor_high[29:16];
    if (res_count >= MAX_RESOURCES) begin
      note_error(ST_FULL);
      return;
    end
    ri = res_count;
    res_base[ri] = base;
    res_count++;
    // First buffer in table order that lies within one stride wins. A zero
    // stride can never satisfy the distance test, so it always opens a buffer.
    for (int b = 0; b < buf_count; b++) begin
      low = (base < buf_addr[b]) ? base : buf_addr[b];
      if (buf_strd[b] != strd || buf_slt[b] != d.fetch_slot) continue;
      if ((base - low) >= strd || (buf_addr[b] - low) >= strd) continue;
      if (buf_rec[b] != d.record_count) begin
        note_error(ST_RECORDS);
        return;
      end
      if (buf_attrs[b] >= MAX_ATTRS) begin
        note_error(ST_ATTR_OVF);
        return;
      end
      buf_addr[b] = low;
      attr_list[b][buf_attrs[b]] = NUM_W'(ri);
      buf_attrs[b]++;
      return;
    end
    if (buf_count >= MAX_RESOURCES) begin
      note_error(ST_FULL);
      return;
    end
    buf_addr[buf_count]     = base;
    buf_strd[buf_count]     = strd;
    buf_rec[buf_count]      = d.record_count;
    buf_slt[buf_count]      = d.fetch_slot;
    buf_attrs[buf_count]    = 1;
    attr_list[buf_count][0] = NUM_W'(ri);
    buf_count++;
  endfunction

  function automatic void predict_request(input vbc_in_t d);
    vbc_out_t r;
    logic [ADDR_W-1:0] diff;
    if (sticky_err == ST_OK) coalesce_desc(d);
    if (!d.final_item) return;
    if (sticky_err != ST_OK) begin
      r = '0;
      r.status      = sticky_err;
      r.last_in_run = 1'b1;
      expected_attrs.push_back(r);
    end else begin
      for (int b = 0; b < buf_count; b++) begin
        for (int k = 0; k < buf_attrs[b]; k++) begin
          r = '0;
          r.buffer_number     = NUM_W'(b);
          r.buffer_address    = buf_addr[b];
          r.buffer_stride     = buf_strd[b];
          r.buffer_records    = buf_rec[b];
          r.buffer_fetch_slot = buf_slt[b];
          r.resource_number   = attr_list[b][k];
          diff = res_base[attr_list[b][k]] - buf_addr[b];
          r.attribute_offset  = diff[STRIDE_W-1:0];
          r.status            = ST_OK;
          expected_attrs.push_back(r);
        end
      end
      // The final item itself always lands somewhere, so the set is never empty.
      expected_attrs[expected_attrs.size()-1].last_in_run = 1'b1;
    end
    clear_tables();
  endfunction

  function automatic void cmp_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tables();
      expected_attrs.delete();
      fail_count   = 0;
      results_seen = 0;
      error_closes = 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        if (expected_attrs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_res);
          fail_count++;
        end else begin
          vbc_out_t want;
          want = expected_attrs.pop_front();
          if (want.status != ST_OK) error_closes++;
          cmp_field("buffer_number", want.buffer_number, out_res.buffer_number);
          cmp_field("buffer_address", want.buffer_address, out_res.buffer_address);
          cmp_field("buffer_stride", want.buffer_stride, out_res.buffer_stride);
          cmp_field("buffer_records", want.buffer_records, out_res.buffer_records);
          cmp_field("buffer_fetch_slot", want.buffer_fetch_slot,
                    out_res.buffer_fetch_slot);
          cmp_field("resource_number", want.resource_number, out_res.resource_number);
          cmp_field("attribute_offset", want.attribute_offset, out_res.attribute_offset);
          cmp_field("status", want.status, out_res.status);
          cmp_field("last_in_run", want.last_in_run, out_res.last_in_run);
        end
      end
      if (start && !busy) predict_request(in_desc);
    end
    expected_left = expected_attrs.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex buffer coalescer testbench
// Sends directed and random descriptor sets with random sender gaps and lets
// the checker compare every attribute result against its own prediction.
// ----------------------------------------------------------------------------
module tb_top import vbc_pkg::*; ();

  localparam int ITEM_TARGET = 370;
  localparam int QUIET_FROM  = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  vbc_in_t  in_desc;
  logic     out_valid;
  vbc_out_t out_res;

  int fail_count;
  int expected_left;
  int results_seen;
  int error_closes;
  int cycles = 0;
  int items_sent = 0;
  int sets_closed = 0;
  int gap_odds = 0;

  always #6 clk = ~clk;

  vertex_buffer_coalescer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_desc   (in_desc),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  vbc_checker coalesce_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_desc       (in_desc),
    .out_valid     (out_valid),
    .out_res       (out_res),
    .fail_count    (fail_count),
    .expected_left (expected_left),
    .results_seen  (results_seen),
    .error_closes  (error_closes)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("vertex_buffer_coalescer_core verification failed");
      $finish;
    end
  end

  function automatic vbc_in_t make_desc(input logic [ADDR_W-1:0] addr,
                                        input logic [STRIDE_W-1:0] strd,
                                        input logic [REC_W-1:0] rec,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic fin);
    vbc_in_t d;
    d.descriptor_low  = addr[31:0];
    d.descriptor_high = {2'($urandom), strd, addr[47:32]};
    d.record_count    = rec;
    d.fetch_slot      = slot;
    d.final_item      = fin;
    return d;
  endfunction

  // Holds start until the request is taken, then maybe idles for a burst.
  task automatic send_desc(input vbc_in_t d);
    int gap;
    start   <= 1'b1;
    in_desc <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (d.final_item) sets_closed++;
    if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      gap = $urandom_range(7, 1);
      start   <= 1'b0;
      in_desc <= {32'($urandom), 32'($urandom), 32'($urandom), 8'($urandom),
                  1'($urandom)};
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    logic [ADDR_W-1:0] a;
    send_desc('1);
    send_desc('0);
    // Merging with the buffer address dropping, one descriptor out of reach
    // and one on another fetch slot.
    a = 48'h1234_0000_1000;
    send_desc(make_desc(a, 14'd16, 32'd100, 8'd5, 1'b0));
    send_desc(make_desc(a + 48'd4, 14'd16, 32'd100, 8'd5, 1'b0));
    send_desc(make_desc(a - 48'd8, 14'd16, 32'd100, 8'd5, 1'b0));
    send_desc(make_desc(a + 48'd20, 14'd16, 32'd100, 8'd5, 1'b0));
    send_desc(make_desc(a, 14'd16, 32'd100, 8'd6, 1'b1));
    // Repeated downward merges push the first offset past the 14-bit range.
    a = 48'hffff_0000_9000;
    send_desc(make_desc(a, 14'h3fff, 32'hffff_ffff, 8'hff, 1'b0));
    send_desc(make_desc(a - 48'h3000, 14'h3fff, 32'hffff_ffff, 8'hff, 1'b0));
    send_desc(make_desc(a - 48'h6000, 14'h3fff, 32'hffff_ffff, 8'hff, 1'b0));
    send_desc(make_desc(a - 48'h9000, 14'h3fff, 32'hffff_ffff, 8'hff, 1'b1));
    // Identical zero-stride descriptors must open separate buffers.
    send_desc(make_desc(48'h40, 14'd0, 32'd3, 8'd1, 1'b0));
    send_desc(make_desc(48'h40, 14'd0, 32'd3, 8'd1, 1'b1));
    // Record count mismatch, then a request that the sticky error swallows.
    a = 48'h0000_8000_0000;
    send_desc(make_desc(a, 14'd32, 32'd7, 8'd0, 1'b0));
    send_desc(make_desc(a + 48'd1, 14'd32, 32'd8, 8'd0, 1'b0));
    send_desc(make_desc(a + 48'd2, 14'd32, 32'd7, 8'd0, 1'b1));
    // Different stride means no merge, so differing counts are fine.
    send_desc(make_desc(a, 14'd32, 32'd7, 8'd0, 1'b0));
    send_desc(make_desc(a + 48'd1, 14'd33, 32'd8, 8'd0, 1'b1));
  endtask

  function automatic logic [STRIDE_W-1:0] pick_stride();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      2, 3:    return STRIDE_W'($urandom);
      default: return STRIDE_W'($urandom_range(64, 1));
    endcase
  endfunction

  // One descriptor set clustered around a base so that merges are common;
  // now and then a set runs past the table size or is plain noise.
  task automatic run_random_set();
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   addr;
    logic [STRIDE_W-1:0] strides [2];
    logic [REC_W-1:0]    recs [2];
    logic [SLOT_W-1:0]   slots [2];
    logic [STRIDE_W-1:0] s;
    int n;
    int kind;
    int off;
    gap_odds = (items_sent >= QUIET_FROM) ? 0 : $urandom_range(2, 0) * 3;
    kind = $urandom_range(9, 0);
    if (kind == 0) begin
      send_desc({32'($urandom), 32'($urandom), 32'($urandom), 8'($urandom),
                 1'($urandom_range(3, 0) == 0)});
      return;
    end
    n = (kind == 1) ? $urandom_range(19, 15) : $urandom_range(10, 1);
    base = {16'($urandom), 32'($urandom)};
    if (kind == 2) base = {ADDR_W{base[0]}} ^ ADDR_W'($urandom_range(200, 0));
    strides[0] = pick_stride();
    strides[1] = pick_stride();
    recs[0]    = $urandom;
    recs[1]    = ($urandom_range(1, 0) == 0) ? recs[0] + 1 : $urandom;
    slots[0]   = SLOT_W'($urandom);
    slots[1]   = SLOT_W'($urandom);
    for (int j = 0; j < n; j++) begin
      s = strides[$urandom_range(4, 0) == 0];
      off = $urandom_range(4 * s, 0) - 2 * s;
      addr = base + ADDR_W'(off);
      send_desc(make_desc(addr, s, recs[$urandom_range(11, 0) == 0],
                          slots[$urandom_range(4, 0) == 0], j == n - 1));
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_desc <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_odds = 3;
    run_directed();
    while (items_sent < ITEM_TARGET) run_random_set();
    start <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d descriptors in %0d closed sets over %0d cycles.",
             items_sent, sets_closed, cycles);
    $display("Checked %0d results, %0d of them error closes of a set.",
             results_seen, error_closes);
    if (fail_count == 0) begin
      $display("vertex_buffer_coalescer_core verification clean");
    end else begin
      $display("vertex_buffer_coalescer_core verification failed");
    end
    $finish;
  end

endmodule
